@@ src/gts_pkg.sv @@
// Package for the grammar token scanner: payload structs, result bundle type,
// scan modes, token kinds and character class helpers. No dependencies.
package gts_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 16;
  localparam int LEN_BITS    = 16;
  localparam int MAX_RES     = 4;
  localparam int CNT_BITS    = 3;
  localparam int IDX_BITS    = 2;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};

  localparam logic [2:0] K_NT    = 3'd0;
  localparam logic [2:0] K_LIT   = 3'd1;
  localparam logic [2:0] K_SEMI  = 3'd2;
  localparam logic [2:0] K_ARROW = 3'd3;
  localparam logic [2:0] K_EPS   = 3'd4;
  localparam logic [2:0] K_EOF   = 3'd5;
  localparam logic [2:0] K_BAD   = 3'd6;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [3:0] {
    M_BETWEEN  = 4'd0,
    M_NONTERM  = 4'd1,
    M_LITERAL  = 4'd2,
    M_SLASH    = 4'd3,
    M_DASH     = 4'd4,
    M_E        = 4'd5,
    M_EP       = 4'd6,
    M_LINECOM  = 4'd7,
    M_BLOCKCOM = 4'd8,
    M_WAIT     = 4'd9
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic                   is_record;
    logic [2:0]             token_kind;
    logic [7:0]             value_char;
    logic [LEN_BITS-1:0]    token_length;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LINE_BITS-1:0]   start_row;
    logic [LINE_BITS-1:0]   start_col;
    logic                   run_last;
  } out_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]    cnt;
    out_t [MAX_RES-1:0]     res;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'hFF);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

@@ src/gts_front.sv @@
// Front end: accepts source bytes, runs the scan state and location counters,
// and builds one bundle of up to four results per byte. Uses gts_pkg.
module gts_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  gts_pkg::in_t     in_data,
  output gts_pkg::bundle_t bundle
);
  import gts_pkg::*;

  mode_t                  mode_r, mode_nxt;
  logic                   star_r, star_nxt;
  logic                   esc_r, esc_nxt;
  logic [OFFSET_BITS-1:0] coff_r, coff_nxt;
  logic [LINE_BITS-1:0]   crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic [OFFSET_BITS-1:0] toff_r, toff_nxt;
  logic [LINE_BITS-1:0]   trow_r, trow_nxt, tcol_r, tcol_nxt;
  logic [LEN_BITS-1:0]    tlen_r, tlen_nxt;

  always_comb begin
    logic [7:0]          c;
    logic                run_between;
    logic                eof_go;
    logic [CNT_BITS-1:0] n;
    out_t                rec;
    c = in_data.byte_value;
    run_between = 1'b0;
    eof_go = 1'b0;
    n = '0;
    rec = '0;
    bundle = '0;
    mode_nxt = mode_r;
    star_nxt = star_r;
    esc_nxt = esc_r;
    toff_nxt = toff_r;
    trow_nxt = trow_r;
    tcol_nxt = tcol_r;
    tlen_nxt = tlen_r;

    if (mode_r != M_WAIT) begin
      unique case (mode_r)
        M_BETWEEN: run_between = 1'b1;
        M_NONTERM: begin
          if (is_letter(c) || c == CH_UNDER) begin
            if (tlen_nxt != LEN_MAX) tlen_nxt = tlen_nxt + 1'b1;
            rec = '{1'b0, K_NT, c, '0, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
            bundle.res[n[IDX_BITS-1:0]] = rec;
            n = n + 1'b1;
          end else begin
            rec = '{1'b1, K_NT, 8'd0, tlen_nxt, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
            bundle.res[n[IDX_BITS-1:0]] = rec;
            n = n + 1'b1;
            mode_nxt = M_BETWEEN;
            run_between = 1'b1;
          end
        end
        M_LITERAL: begin
          if (!esc_nxt && c == CH_QUOTE) begin
            rec = '{1'b1, K_LIT, 8'd0, tlen_nxt, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
            bundle.res[n[IDX_BITS-1:0]] = rec;
            n = n + 1'b1;
            mode_nxt = M_BETWEEN;
          end else begin
            if (esc_nxt || c != CH_BSL) begin
              rec = '{1'b0, K_LIT, c, '0, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
              bundle.res[n[IDX_BITS-1:0]] = rec;
              n = n + 1'b1;
            end
            esc_nxt = !esc_nxt && c == CH_BSL;
            if (tlen_nxt != LEN_MAX) tlen_nxt = tlen_nxt + 1'b1;
          end
        end
        M_SLASH, M_DASH, M_E, M_EP: begin
          if (mode_r == M_SLASH && c == CH_STAR) begin
            mode_nxt = M_BLOCKCOM;
            star_nxt = 1'b0;
          end else if (mode_r == M_SLASH && c == CH_SLASH) begin
            mode_nxt = M_LINECOM;
          end else if (mode_r == M_DASH && c == CH_GT) begin
            rec = '{1'b1, K_ARROW, 8'd0, 16'd2, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
            bundle.res[n[IDX_BITS-1:0]] = rec;
            n = n + 1'b1;
            mode_nxt = M_BETWEEN;
          end else if (mode_r == M_E && c == CH_P) begin
            mode_nxt = M_EP;
          end else if (mode_r == M_EP && c == CH_S) begin
            rec = '{1'b1, K_EPS, 8'd0, 16'd3, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
            bundle.res[n[IDX_BITS-1:0]] = rec;
            n = n + 1'b1;
            mode_nxt = M_BETWEEN;
          end else begin
            rec = '{1'b1, K_BAD, 8'd0, '0, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
            bundle.res[n[IDX_BITS-1:0]] = rec;
            n = n + 1'b1;
            mode_nxt = M_WAIT;
          end
        end
        M_LINECOM: begin
          if (c == CH_LF) mode_nxt = M_BETWEEN;
        end
        M_BLOCKCOM: begin
          if (c != CH_LF) begin
            if (star_nxt && c == CH_SLASH) mode_nxt = M_BETWEEN;
            else star_nxt = (c == CH_STAR);
          end
        end
        default: mode_nxt = M_WAIT;
      endcase
    end

    if (run_between && !is_ws(c)) begin
      toff_nxt = coff_r;
      trow_nxt = crow_r;
      tcol_nxt = ccol_r;
      if (c == CH_SLASH) begin
        mode_nxt = M_SLASH;
      end else if (c == CH_SEMI) begin
        rec = '{1'b1, K_SEMI, 8'd0, 16'd1, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
        bundle.res[n[IDX_BITS-1:0]] = rec;
        n = n + 1'b1;
      end else if (c == CH_DASH) begin
        mode_nxt = M_DASH;
      end else if (c == CH_E) begin
        mode_nxt = M_E;
      end else if (is_upper(c)) begin
        mode_nxt = M_NONTERM;
        tlen_nxt = 16'd1;
        rec = '{1'b0, K_NT, c, '0, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
        bundle.res[n[IDX_BITS-1:0]] = rec;
        n = n + 1'b1;
      end else if (c == CH_QUOTE) begin
        mode_nxt = M_LITERAL;
        tlen_nxt = 16'd2;
        esc_nxt = 1'b0;
      end else begin
        rec = '{1'b1, K_BAD, 8'd0, '0, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
        bundle.res[n[IDX_BITS-1:0]] = rec;
        n = n + 1'b1;
        mode_nxt = M_WAIT;
      end
    end

    coff_nxt = coff_r + 1'b1;
    if (c == CH_LF) begin
      crow_nxt = (crow_r != LINE_MAX) ? crow_r + 1'b1 : crow_r;
      ccol_nxt = LINE_BITS'(1);
    end else begin
      crow_nxt = crow_r;
      ccol_nxt = (ccol_r != LINE_MAX) ? ccol_r + 1'b1 : ccol_r;
    end

    if (in_data.final_byte) begin
      eof_go = 1'b1;
      unique case (mode_nxt)
        M_WAIT: eof_go = 1'b0;
        M_NONTERM: begin
          rec = '{1'b1, K_NT, 8'd0, tlen_nxt, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
          bundle.res[n[IDX_BITS-1:0]] = rec;
          n = n + 1'b1;
        end
        M_LITERAL: begin
          rec = '{1'b1, K_BAD, 8'd0, tlen_nxt, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
          bundle.res[n[IDX_BITS-1:0]] = rec;
          n = n + 1'b1;
        end
        M_SLASH, M_DASH, M_E, M_EP: begin
          rec = '{1'b1, K_BAD, 8'd0, '0, toff_nxt, trow_nxt, tcol_nxt, 1'b0};
          bundle.res[n[IDX_BITS-1:0]] = rec;
          n = n + 1'b1;
          eof_go = 1'b0;
        end
        default: ;
      endcase
      if (eof_go) begin
        rec = '{1'b1, K_EOF, 8'd0, '0, coff_nxt, crow_nxt, ccol_nxt, 1'b0};
        bundle.res[n[IDX_BITS-1:0]] = rec;
        n = n + 1'b1;
      end
      mode_nxt = M_BETWEEN;
      star_nxt = 1'b0;
      esc_nxt = 1'b0;
      coff_nxt = '0;
      crow_nxt = LINE_BITS'(1);
      ccol_nxt = LINE_BITS'(1);
      toff_nxt = '0;
      trow_nxt = LINE_BITS'(1);
      tcol_nxt = LINE_BITS'(1);
      tlen_nxt = '0;
    end

    if (n != '0) bundle.res[n[IDX_BITS-1:0] - 1'b1].run_last = 1'b1;
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      star_r <= 1'b0;
      esc_r  <= 1'b0;
      coff_r <= '0;
      crow_r <= LINE_BITS'(1);
      ccol_r <= LINE_BITS'(1);
      toff_r <= '0;
      trow_r <= LINE_BITS'(1);
      tcol_r <= LINE_BITS'(1);
      tlen_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      star_r <= star_nxt;
      esc_r  <= esc_nxt;
      coff_r <= coff_nxt;
      crow_r <= crow_nxt;
      ccol_r <= ccol_nxt;
      toff_r <= toff_nxt;
      trow_r <= trow_nxt;
      tcol_r <= tcol_nxt;
      tlen_r <= tlen_nxt;
    end
  end

endmodule

@@ src/gts_queue.sv @@
// Two-entry queue of result bundles between the front end and the back end.
// Uses gts_pkg.
module gts_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gts_pkg::bundle_t push_data,
  input  logic             pop,
  output gts_pkg::bundle_t head,
  output logic             empty,
  output logic             full,
  output logic [1:0]       level
);
  import gts_pkg::*;

  bundle_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign level = cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/gts_back.sv @@
// Back end: walks the results of the head bundle and hands them out one beat
// at a time. Uses gts_pkg.
module gts_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gts_pkg::bundle_t head,
  input  logic             empty,
  input  logic             out_ready,
  output logic             out_valid,
  output gts_pkg::out_t    out_data,
  output logic             pop
);
  import gts_pkg::*;

  logic [IDX_BITS-1:0] idx_r;
  logic                last;

  assign out_valid = !empty;
  assign out_data  = head.res[idx_r];
  assign last      = ({1'b0, idx_r} + 1'b1) == head.cnt;
  assign pop       = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_valid && out_ready) begin
      idx_r <= last ? '0 : idx_r + 1'b1;
    end
  end

endmodule

@@ src/grammar_token_scanner_top.sv @@
// Grammar token scanner top level: front end, bundle queue and back end.
// Each byte's results go into the bundle queue when the byte is accepted.
// Input: one byte per cycle while the queue is not full. Each result a byte
// causes (zero to four) is a beat of the back end's single output port.
// Reset: synchronous active-low rst_n clears scan state and empties the queue.
module grammar_token_scanner_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gts_pkg::out_t out_data
);
  import gts_pkg::*;

  bundle_t    bundle, head;
  logic       take, push, pop, empty, full;
  logic [1:0] level;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;
  assign push     = take && (bundle.cnt != '0);

  gts_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .in_data(in_data), .bundle(bundle)
  );

  gts_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(bundle), .pop(pop),
    .head(head), .empty(empty), .full(full), .level(level)
  );

  gts_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data), .pop(pop)
  );

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level != 2'd3) else $error("queue level overflow");

  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.cnt != '0)) else $error("empty bundle in queue");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> out_data.run_last) else $error("bundle retired before its last beat");

endmodule

@@ bench/testbench.sv @@
// Testbench for grammar_token_scanner_top: directed and random byte streams of grammar
// source, results checked against a behavioral scanner model. Needs gts_pkg, top level.
`timescale 1ns / 100ps

module testbench;
  import gts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  grammar_token_scanner_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  mode_t sc_mode;
  logic sc_star, sc_esc;
  logic [OFFSET_BITS-1:0] sc_off, tk_off;
  logic [LINE_BITS-1:0] sc_row, sc_col, tk_row, tk_col;
  logic [LEN_BITS-1:0] tk_len;

  out_t token_q[$];
  out_t step_res[$];
  int n_errors = 0;
  int n_results = 0;
  int n_bytes = 0;
  int n_records = 0;

  typedef struct {
    logic [7:0] b;
    logic fin;
    int n_fixed;
    out_t fixed0;
  } row_t;

  function automatic out_t mk(logic rec, logic [2:0] k, logic [7:0] ch, logic [15:0] len,
                               logic [OFFSET_BITS-1:0] off, logic [LINE_BITS-1:0] r,
                               logic [LINE_BITS-1:0] c);
    out_t o;
    o.is_record = rec; o.token_kind = k; o.value_char = ch; o.token_length = len;
    o.start_offset = off; o.start_row = r; o.start_col = c; o.run_last = 1'b0;
    return o;
  endfunction

  task automatic scanner_clear();
    sc_mode = M_BETWEEN; sc_star = 1'b0; sc_esc = 1'b0;
    sc_off = '0; sc_row = LINE_BITS'(1); sc_col = LINE_BITS'(1);
    tk_off = '0; tk_row = LINE_BITS'(1); tk_col = LINE_BITS'(1); tk_len = '0;
  endtask

  task automatic emit_tok(logic [2:0] k, logic [15:0] len);
    step_res.push_back(mk(1'b1, k, 8'h00, len, tk_off, tk_row, tk_col));
  endtask

  task automatic tok_fail();
    emit_tok(K_BAD, 16'd0);
    sc_mode = M_WAIT;
  endtask

  task automatic len_up();
    if (tk_len != LEN_MAX) tk_len = tk_len + 1'b1;
  endtask

  task automatic scan_between(logic [7:0] c);
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || c == 8'hFF) return;
    tk_off = sc_off; tk_row = sc_row; tk_col = sc_col;
    if (c == CH_SLASH) sc_mode = M_SLASH;
    else if (c == CH_SEMI) emit_tok(K_SEMI, 16'd1);
    else if (c == CH_DASH) sc_mode = M_DASH;
    else if (c == CH_E) sc_mode = M_E;
    else if (c >= 8'h41 && c <= 8'h5A) begin
      sc_mode = M_NONTERM;
      tk_len = 16'd1;
      step_res.push_back(mk(1'b0, K_NT, c, 16'd0, tk_off, tk_row, tk_col));
    end else if (c == CH_QUOTE) begin
      sc_mode = M_LITERAL;
      tk_len = 16'd2;
      sc_esc = 1'b0;
    end else tok_fail();
  endtask

  task automatic scan_byte(logic [7:0] c);
    case (sc_mode)
      M_BETWEEN: scan_between(c);
      M_NONTERM: begin
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER) begin
          len_up();
          step_res.push_back(mk(1'b0, K_NT, c, 16'd0, tk_off, tk_row, tk_col));
        end else begin
          emit_tok(K_NT, tk_len);
          sc_mode = M_BETWEEN;
          scan_between(c);
        end
      end
      M_LITERAL: begin
        if (!sc_esc && c == CH_QUOTE) begin
          emit_tok(K_LIT, tk_len);
          sc_mode = M_BETWEEN;
        end else begin
          if (sc_esc || c != CH_BSL)
            step_res.push_back(mk(1'b0, K_LIT, c, 16'd0, tk_off, tk_row, tk_col));
          sc_esc = !sc_esc && c == CH_BSL;
          len_up();
        end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin
          sc_mode = M_BLOCKCOM; sc_star = 1'b0;
        end else if (c == CH_SLASH) sc_mode = M_LINECOM;
        else tok_fail();
      end
      M_DASH: begin
        if (c == CH_GT) begin
          emit_tok(K_ARROW, 16'd2); sc_mode = M_BETWEEN;
        end else tok_fail();
      end
      M_E: begin
        if (c == CH_P) sc_mode = M_EP;
        else tok_fail();
      end
      M_EP: begin
        if (c == CH_S) begin
          emit_tok(K_EPS, 16'd3); sc_mode = M_BETWEEN;
        end else tok_fail();
      end
      M_LINECOM: if (c == CH_LF) sc_mode = M_BETWEEN;
      M_BLOCKCOM: begin
        if (c != CH_LF) begin
          if (sc_star && c == CH_SLASH) sc_mode = M_BETWEEN;
          else sc_star = (c == CH_STAR);
        end
      end
      default: sc_mode = M_WAIT;
    endcase
  endtask

  task automatic predict_tokens(logic [7:0] c, logic fin);
    logic skip_eof;
    step_res.delete();
    skip_eof = 1'b0;
    if (sc_mode != M_WAIT) scan_byte(c);
    sc_off = sc_off + 1'b1;
    if (c == CH_LF) begin
      if (sc_row != LINE_MAX) sc_row = sc_row + 1'b1;
      sc_col = LINE_BITS'(1);
    end else if (sc_col != LINE_MAX) sc_col = sc_col + 1'b1;
    if (fin) begin
      case (sc_mode)
        M_WAIT: skip_eof = 1'b1;
        M_NONTERM: emit_tok(K_NT, tk_len);
        M_LITERAL: emit_tok(K_BAD, tk_len);
        M_SLASH, M_DASH, M_E, M_EP: begin
          emit_tok(K_BAD, 16'd0); skip_eof = 1'b1;
        end
        default: ;
      endcase
      if (!skip_eof) step_res.push_back(mk(1'b1, K_EOF, 8'h00, 16'd0, sc_off, sc_row, sc_col));
      scanner_clear();
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].run_last = 1'b1;
  endtask

  task automatic report_mismatch(string what);
    n_errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // The handshake inputs change only at rising edges, so they are sampled at the
  // falling edge ahead of the accepting edge.
  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{byte_value: b, final_byte: fin};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_tokens(b, fin);
    foreach (step_res[i]) token_q.push_back(step_res[i]);
    n_bytes++;
  endtask

  // Sink side: a beat is checked against the oldest expectation.
  initial begin
    int stall;
    out_t exp_tok;
    out_t got;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = out_data;
      @(posedge clk);
      n_results++;
      if (token_q.size() == 0) report_mismatch("result beat with nothing expected");
      else begin
        exp_tok = token_q.pop_front();
        if (got.is_record !== exp_tok.is_record) report_mismatch("is_record");
        if (got.token_kind !== exp_tok.token_kind) report_mismatch("token_kind");
        if (got.value_char !== exp_tok.value_char) report_mismatch("value_char");
        if (got.token_length !== exp_tok.token_length) report_mismatch("token_length");
        if (got.start_offset !== exp_tok.start_offset) report_mismatch("start_offset");
        if (got.start_row !== exp_tok.start_row) report_mismatch("start_row");
        if (got.start_col !== exp_tok.start_col) report_mismatch("start_col");
        if (got.run_last !== exp_tok.run_last) report_mismatch("run_last");
        if (exp_tok.is_record) n_records++;
      end
    end
  end

  string frags[] = '{"Expr", "Term_x", "\"ab\\\"c\"", ";", "->", "eps", " ", "\n", "\t",
                     "// note\n", "/* a*b **/", "\"\\\\\"", "A", "\015", "\xff"};

  initial begin
    row_t dir[$];
    row_t r;
    string s;
    int nsrc, k, nf;
    logic [7:0] b;
    scanner_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    s = "Ab_z -> \"q\\\"\" eps;";
    for (int i = 0; i < s.len(); i++) begin
      r.b = s[i]; r.fin = (i == s.len()-1); r.n_fixed = 0; dir.push_back(r);
    end
    r = '{b: 8'h01, fin: 1'b1, n_fixed: 1,
          fixed0: mk(1'b1, K_BAD, 8'h00, 16'd0, 24'd0, 16'd1, 16'd1)};
    dir.push_back(r);
    r = '{b: 8'hFF, fin: 1'b1, n_fixed: 1,
          fixed0: mk(1'b1, K_EOF, 8'h00, 16'd0, 24'd1, 16'd1, 16'd2)};
    dir.push_back(r);
    r = '{b: CH_DASH, fin: 1'b1, n_fixed: 1,
          fixed0: mk(1'b1, K_BAD, 8'h00, 16'd0, 24'd0, 16'd1, 16'd1)};
    dir.push_back(r);
    r = '{b: CH_E, fin: 1'b0, n_fixed: 0, fixed0: '0}; dir.push_back(r);
    r = '{b: CH_P, fin: 1'b0, n_fixed: 0, fixed0: '0}; dir.push_back(r);
    r = '{b: 8'h00, fin: 1'b0, n_fixed: 1,
          fixed0: mk(1'b1, K_BAD, 8'h00, 16'd0, 24'd0, 16'd1, 16'd1)};
    dir.push_back(r);
    r = '{b: 8'h80, fin: 1'b1, n_fixed: 0, fixed0: '0}; dir.push_back(r);
    r = '{b: CH_QUOTE, fin: 1'b1, n_fixed: 1,
          fixed0: mk(1'b1, K_BAD, 8'h00, 16'd2, 24'd0, 16'd1, 16'd1)};
    dir.push_back(r);
    foreach (dir[i]) begin
      send_byte(dir[i].b, dir[i].fin);
      if (dir[i].n_fixed > 0) begin
        if (step_res.size() == 0)
          report_mismatch("directed row expects a result the scanner model does not give");
        else if (step_res[0] != {dir[i].fixed0[$bits(out_t)-1:1], step_res[0].run_last})
          report_mismatch("directed row disagrees with scanner model");
      end
    end
    nsrc = 0;
    while (n_bytes < 245) begin
      nf = $urandom_range(1, 8);
      for (int f = 0; f < nf; f++) begin
        k = $urandom_range(0, 9);
        if (k < 8) s = frags[$urandom_range(0, frags.size()-1)];
        else if (k == 8) begin
          s = "\"";
          repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE || b == CH_BSL) b = "z";
            s = {s, string'(b)};
          end
          s = {s, "\""};
        end else s = string'(8'($urandom_range(0, 255)));
        for (int i = 0; i < s.len(); i++)
          send_byte(s[i], (f == nf-1) && (i == s.len()-1) && (s.len() > 0));
        if (s.len() == 0) send_byte(8'h20, f == nf-1);
      end
      nsrc++;
    end
    repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Scanned %0d bytes in %0d random sources; %0d result beats, %0d records.",
             n_bytes, nsrc, n_results, n_records);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3ms;
    $display("Timeout with %0d results still expected.", token_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
